>>> rtl/next_prime_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the next prime search block
// The checks are clocked on clk and are held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef NEXT_PRIME_SEARCH_DEFINES_SVH
`define NEXT_PRIME_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Types, constants and the microcode program of the next prime search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 31;
  localparam int FLOOR_VALUE         = 9;
  localparam int FIRST_DIVISOR       = 3;
  localparam int CANDIDATE_STEP      = 2;

  localparam int PC_WIDTH = 4;
  typedef logic [PC_WIDTH-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_D,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_NEXT_D,
    OP_NEXT_CAND,
    OP_EMIT_CAND,
    OP_EMIT_FLOOR,
    OP_EMIT_LIMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SMALL,
    C_OVER,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_REM_NONZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  // Program addresses.
  localparam pc_t PC_FETCH      = 4'd0;
  localparam pc_t PC_FLOOR_CHK  = 4'd1;
  localparam pc_t PC_CAND_TOP   = 4'd2;
  localparam pc_t PC_DIV_START  = 4'd3;
  localparam pc_t PC_DIV_STEP   = 4'd4;
  localparam pc_t PC_BOUND_CHK  = 4'd5;
  localparam pc_t PC_REM_CHK    = 4'd6;
  localparam pc_t PC_CAND_NEXT  = 4'd7;
  localparam pc_t PC_WAIT_CAND  = 4'd8;
  localparam pc_t PC_EMIT_CAND  = 4'd9;
  localparam pc_t PC_WAIT_FLOOR = 4'd10;
  localparam pc_t PC_EMIT_FLOOR = 4'd11;
  localparam pc_t PC_WAIT_LIMIT = 4'd12;
  localparam pc_t PC_EMIT_LIMIT = 4'd13;

  // Each word runs its operation, then jumps to target when the condition
  // holds and falls through to the next address otherwise.
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_FETCH};
    case (pc)
      PC_FETCH:      w = '{op: OP_LOAD,       cond: C_NO_INPUT,    target: PC_FETCH};
      PC_FLOOR_CHK:  w = '{op: OP_NONE,       cond: C_SMALL,       target: PC_WAIT_FLOOR};
      PC_CAND_TOP:   w = '{op: OP_INIT_D,     cond: C_OVER,        target: PC_WAIT_LIMIT};
      PC_DIV_START:  w = '{op: OP_DIV_START,  cond: C_NEVER,       target: PC_FETCH};
      PC_DIV_STEP:   w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY,    target: PC_DIV_STEP};
      PC_BOUND_CHK:  w = '{op: OP_NONE,       cond: C_D_GT_Q,      target: PC_WAIT_CAND};
      PC_REM_CHK:    w = '{op: OP_NEXT_D,     cond: C_REM_NONZERO, target: PC_DIV_START};
      PC_CAND_NEXT:  w = '{op: OP_NEXT_CAND,  cond: C_ALWAYS,      target: PC_CAND_TOP};
      PC_WAIT_CAND:  w = '{op: OP_NONE,       cond: C_OUT_BUSY,    target: PC_WAIT_CAND};
      PC_EMIT_CAND:  w = '{op: OP_EMIT_CAND,  cond: C_ALWAYS,      target: PC_FETCH};
      PC_WAIT_FLOOR: w = '{op: OP_NONE,       cond: C_OUT_BUSY,    target: PC_WAIT_FLOOR};
      PC_EMIT_FLOOR: w = '{op: OP_EMIT_FLOOR, cond: C_ALWAYS,      target: PC_FETCH};
      PC_WAIT_LIMIT: w = '{op: OP_NONE,       cond: C_OUT_BUSY,    target: PC_WAIT_LIMIT};
      PC_EMIT_LIMIT: w = '{op: OP_EMIT_LIMIT, cond: C_ALWAYS,      target: PC_FETCH};
      default:       w = '{op: OP_NONE,       cond: C_ALWAYS,      target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/nps_divider.sv
// ----------------------------------------------------------------------------
// nps_divider
// Restoring divider, one quotient bit per step, driven by the sequencer.
// ----------------------------------------------------------------------------
module nps_divider #(
  parameter int VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nps_pkg::div_ctrl_t     ctrl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder,
  output logic                   last
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [CW-1:0]          count;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  assign trial = {remainder, quotient[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};
  assign last  = count == CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.start) begin
      count <= CW'(VALUE_WIDTH);
    end else if (ctrl.step) begin
      count <= count - CW'(1);
    end
  end

  // The partial remainder stays below the divisor, so both arms fit in
  // VALUE_WIDTH bits.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (ctrl.step) begin
      quotient  <= {quotient[VALUE_WIDTH-2:0], fits};
      remainder <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/next_prime_search.sv
// ----------------------------------------------------------------------------
// next_prime_search
// Odd trial-division prime search run by a small microcode sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  base    | in        | base_valid / base_stall   | base_value  (W bits)
//  prime   | out       | prime_valid / prime_stall | prime_value (W bits)
//
// Each divisor takes a divider load, W divider steps, the bound check and
// the remainder check; a further candidate adds the candidate step and the
// top check. A base of 9 or less goes to the floor emit. Search time is set
// by the one-bit-per-cycle divider, growing with prime gap and square root.
// One transaction is worked at a time; the result register lets the next
// base be taken while the last result is still stalled.
// Reset clears the program counter, the divider step counter and the result valid flag.
// ----------------------------------------------------------------------------
`include "next_prime_search_defines.svh"

module next_prime_search #(
  parameter int VALUE_WIDTH = nps_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   base_valid,
  output logic                   base_stall,
  input  logic [VALUE_WIDTH-1:0] base_value,
  output logic                   prime_valid,
  input  logic                   prime_stall,
  output logic [VALUE_WIDTH-1:0] prime_value
);

  localparam int W = VALUE_WIDTH;

  nps_pkg::pc_t       pc;
  nps_pkg::pc_t       pc_next;
  nps_pkg::ucode_t    uword;
  nps_pkg::div_ctrl_t div_ctrl;
  logic               cond_true;

  logic [W:0]   cand;
  logic [W-1:0] d;
  logic         base_at_floor;
  logic [W-1:0] quotient;
  logic [W-1:0] remainder;
  logic         div_last;
  logic         out_free;

  assign uword      = nps_pkg::ucode_rom(pc);
  assign base_stall = pc != nps_pkg::PC_FETCH;
  assign out_free   = !prime_valid || !prime_stall;

  assign div_ctrl.start = uword.op == nps_pkg::OP_DIV_START;
  assign div_ctrl.step  = uword.op == nps_pkg::OP_DIV_STEP;

  always_comb begin
    case (uword.cond)
      nps_pkg::C_NEVER:       cond_true = 1'b0;
      nps_pkg::C_ALWAYS:      cond_true = 1'b1;
      nps_pkg::C_NO_INPUT:    cond_true = !base_valid;
      nps_pkg::C_SMALL:       cond_true = base_at_floor;
      nps_pkg::C_OVER:        cond_true = cand[W];
      nps_pkg::C_DIV_BUSY:    cond_true = !div_last;
      nps_pkg::C_D_GT_Q:      cond_true = d > quotient;
      nps_pkg::C_REM_NONZERO: cond_true = remainder != '0;
      nps_pkg::C_OUT_BUSY:    cond_true = !out_free;
      default:                cond_true = 1'b0;
    endcase
    pc_next = cond_true ? uword.target : pc + nps_pkg::pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= nps_pkg::PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Candidate, divisor and floor flag registers.
  always_ff @(posedge clk) begin
    case (uword.op)
      nps_pkg::OP_LOAD: begin
        cand          <= {1'b0, base_value | W'(1)};
        base_at_floor <= base_value <= W'(nps_pkg::FLOOR_VALUE);
      end
      nps_pkg::OP_INIT_D:    d    <= W'(nps_pkg::FIRST_DIVISOR);
      nps_pkg::OP_NEXT_D:    d    <= d + W'(nps_pkg::CANDIDATE_STEP);
      nps_pkg::OP_NEXT_CAND: cand <= cand + (W+1)'(nps_pkg::CANDIDATE_STEP);
      default: begin
      end
    endcase
  end

  // Result register; an emit step is only reached once the register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime_valid <= 1'b0;
    end else if (uword.op == nps_pkg::OP_EMIT_CAND || uword.op == nps_pkg::OP_EMIT_FLOOR ||
                 uword.op == nps_pkg::OP_EMIT_LIMIT) begin
      prime_valid <= 1'b1;
    end else if (!prime_stall) begin
      prime_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (uword.op)
      nps_pkg::OP_EMIT_CAND:  prime_value <= cand[W-1:0];
      nps_pkg::OP_EMIT_FLOOR: prime_value <= W'(nps_pkg::FLOOR_VALUE);
      nps_pkg::OP_EMIT_LIMIT: prime_value <= '1;
      default: begin
      end
    endcase
  end

  nps_divider #(
    .VALUE_WIDTH(W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (cand[W-1:0]),
    .divisor  (d),
    .quotient (quotient),
    .remainder(remainder),
    .last     (div_last)
  );

  `NPS_ASSERT_NEXT(a_accept_then_floor_check, base_valid && !base_stall,
                   pc == nps_pkg::PC_FLOOR_CHK, "accepted base did not reach the floor check")

  `NPS_ASSERT_SAME(a_emit_only_when_free,
                   uword.op == nps_pkg::OP_EMIT_CAND || uword.op == nps_pkg::OP_EMIT_FLOOR ||
                   uword.op == nps_pkg::OP_EMIT_LIMIT,
                   out_free, "result written while the previous one is still stalled")

  `NPS_ASSERT_SAME(a_rem_below_divisor, pc == nps_pkg::PC_BOUND_CHK,
                   remainder < d, "division left a remainder not below the divisor")

  `NPS_ASSERT_SAME(a_result_at_floor, prime_valid,
                   prime_value >= W'(nps_pkg::FLOOR_VALUE), "result below the floor value")

endmodule
